// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge, quiet while reset is low.
`define ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on the next edge, quiet while reset is low.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hpwd_pkg.sv
package hpwd_pkg;

    localparam int TEMP_BITS = 15;
    localparam int EXT_W     = TEMP_BITS + 3;
    localparam int CFG_W     = 11;

    localparam int IN_BITS  = 1 + 3 * TEMP_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 3 + 4 + 1 + 9 + TEMP_BITS;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [TEMP_BITS-1:0] temp_t;
    typedef logic signed [EXT_W-1:0]     ext_t;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_BOOST = 3'd1;
    localparam logic [2:0] PH_COAST = 3'd2;
    localparam logic [2:0] PH_PID   = 3'd3;
    localparam logic [2:0] PH_SAFE  = 3'd4;

    localparam logic [3:0] EV_STAY      = 4'd0;
    localparam logic [3:0] EV_IDLE      = 4'd1;
    localparam logic [3:0] EV_BOOST     = 4'd2;
    localparam logic [3:0] EV_COAST     = 4'd3;
    localparam logic [3:0] EV_PID       = 4'd4;
    localparam logic [3:0] EV_RECOVERED = 4'd5;
    localparam logic [3:0] EV_NO_RISE   = 4'd6;
    localparam logic [3:0] EV_DROP      = 4'd7;
    localparam logic [3:0] EV_LOW       = 4'd8;

    localparam logic [2:0] REG_NO_RISE_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_MIN_RISE         = 3'd1;
    localparam logic [2:0] REG_EXIT_MARGIN      = 3'd2;
    localparam logic [2:0] REG_COAST_LENGTH     = 3'd3;
    localparam logic [2:0] REG_FALL_LIMIT       = 3'd4;
    localparam logic [2:0] REG_DROP_MARGIN      = 3'd5;
    localparam logic [2:0] REG_DROP_COUNT_LIMIT = 3'd6;
    localparam logic [2:0] REG_SUSTAIN_LIMIT    = 3'd7;

    localparam ext_t       SUSTAIN_MARGIN = EXT_W'(300);
    localparam ext_t       RECOVER_MARGIN = EXT_W'(200);
    localparam logic [8:0] COAST_SEED     = 9'd300;

    typedef struct packed {
        logic [9:0]  no_rise_timeout;
        logic [10:0] min_rise;
        logic [10:0] exit_margin;
        logic [7:0]  coast_length;
        logic [9:0]  fall_limit;
        logic [10:0] drop_margin;
        logic [3:0]  drop_count_limit;
        logic [7:0]  sustain_count_limit;
    } cfg_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [9:0] rise_window_count;
        temp_t      window_start_temp;
        logic [7:0] coast_count;
        logic [3:0] fast_drop_count;
        logic [7:0] low_count;
    } state_t;

    typedef struct packed {
        logic  auto_on;
        temp_t skin_temp;
        temp_t target_temp;
        temp_t last_measure;
    } tick_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] event_res;
        logic       seed_valid;
        logic [8:0] seed_integral;
        temp_t      seed_last_measure;
    } result_t;

    function automatic ext_t ext_temp(temp_t v);
        return ext_t'(v);
    endfunction

    function automatic ext_t ext_cfg(logic [CFG_W-1:0] v);
        return $signed({{(EXT_W - CFG_W){1'b0}}, v});
    endfunction

endpackage

// File: rtl/heater_phase_watchdog_fsm.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tick: auto_on, skin, target, last_measure
// m_axis    out  m_axis_tvalid/m_axis_tready   phase, event, pid seeds
// cfg       in   cfg_we (no wait)              cfg_index, cfg_data
//
// One word per cycle sustained while m_axis_tready stays high.
// A word sits in the input register, the phase logic runs in one pass and the
// result lands in the output register while the state updates.
// Reset clears the phase state and loads the register defaults.
// With the output stalled, one more word is taken into the input register.
`include "assert_macros.svh"

module heater_phase_watchdog_fsm
    import hpwd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // auto_on, skin_temp, target_temp, last_measure, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // phase, event_res, seed_valid, seed_integral, seed_last_measure
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic               in_valid_reg;
    logic [IN_BITS-1:0] in_data_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    state_t             state_reg;
    state_t             state_next;
    cfg_t               cfg_reg;
    tick_t              tick;
    result_t            res;
    logic               adv;

    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_data_reg.seed_last_measure, out_data_reg.seed_integral,
                                   out_data_reg.seed_valid, out_data_reg.event_res,
                                   out_data_reg.phase});

    assign tick.auto_on      = in_data_reg[0];
    assign tick.skin_temp    = in_data_reg[TEMP_BITS:1];
    assign tick.target_temp  = in_data_reg[2*TEMP_BITS:TEMP_BITS+1];
    assign tick.last_measure = in_data_reg[3*TEMP_BITS:2*TEMP_BITS+1];

    hpwd_step u_step (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .tick (tick),
        .nxt  (state_next),
        .res  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata[IN_BITS-1:0];
        end
        if (adv)
        begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.no_rise_timeout     <= 10'd300;
            cfg_reg.min_rise            <= 11'd30;
            cfg_reg.exit_margin         <= 11'd300;
            cfg_reg.coast_length        <= 8'd45;
            cfg_reg.fall_limit          <= 10'd8;
            cfg_reg.drop_margin         <= 11'd200;
            cfg_reg.drop_count_limit    <= 4'd3;
            cfg_reg.sustain_count_limit <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NO_RISE_TIMEOUT:  cfg_reg.no_rise_timeout     <= cfg_data[9:0];
                REG_MIN_RISE:         cfg_reg.min_rise            <= cfg_data;
                REG_EXIT_MARGIN:      cfg_reg.exit_margin         <= cfg_data;
                REG_COAST_LENGTH:     cfg_reg.coast_length        <= cfg_data[7:0];
                REG_FALL_LIMIT:       cfg_reg.fall_limit          <= cfg_data[9:0];
                REG_DROP_MARGIN:      cfg_reg.drop_margin         <= cfg_data;
                REG_DROP_COUNT_LIMIT: cfg_reg.drop_count_limit    <= cfg_data[3:0];
                REG_SUSTAIN_LIMIT:    cfg_reg.sustain_count_limit <= cfg_data[7:0];
            endcase
        end
    end

    `ASSERT_SAME(a_seed_in_pid, out_valid_reg && out_data_reg.seed_valid,
                 out_data_reg.phase == PH_PID, "seed word outside pid")
    `ASSERT_NEXT(a_state_hold, !adv, $stable(state_reg), "state moved without a word")
    `ASSERT_SAME(a_full_when_busy, !s_axis_tready, in_valid_reg && out_valid_reg,
                 "input stalled with room")

endmodule

// File: rtl/hpwd_step.sv
module hpwd_step
    import hpwd_pkg::*;
(
    input  cfg_t    cfg,
    input  state_t  cur,
    input  tick_t   tick,
    output state_t  nxt,
    output result_t res
);

    ext_t       skin;
    ext_t       target;
    ext_t       prev;
    logic [9:0] rise_cnt;
    logic [7:0] coast_cnt;
    logic [3:0] drop_cnt;
    logic [7:0] low_cnt;
    logic       no_rise;
    logic       fast;
    logic       far;
    logic       tripped;

    assign skin   = ext_temp(tick.skin_temp);
    assign target = ext_temp(tick.target_temp);
    assign prev   = ext_temp(tick.last_measure);

    assign rise_cnt  = (cur.rise_window_count == '1) ? cur.rise_window_count
                                                     : cur.rise_window_count + 10'd1;
    assign coast_cnt = (cur.coast_count == '1) ? cur.coast_count : cur.coast_count + 8'd1;
    assign drop_cnt  = (cur.fast_drop_count == '1) ? cur.fast_drop_count
                                                   : cur.fast_drop_count + 4'd1;
    assign low_cnt   = (cur.low_count == '1) ? cur.low_count : cur.low_count + 8'd1;

    assign no_rise = (skin - ext_temp(cur.window_start_temp)) < ext_cfg(cfg.min_rise);
    assign fast    = (prev - skin) > ext_cfg({1'b0, cfg.fall_limit});
    assign far     = skin < (target - ext_cfg(cfg.drop_margin));

    always_comb
    begin
        nxt     = cur;
        res     = '0;
        tripped = 1'b0;
        if (!tick.auto_on)
        begin
            nxt.phase             = PH_IDLE;
            nxt.rise_window_count = '0;
            nxt.coast_count       = '0;
            nxt.low_count         = '0;
            nxt.fast_drop_count   = '0;
            res.event_res         = EV_IDLE;
        end
        else
        begin
            unique case (cur.phase)
                PH_IDLE:
                begin
                    nxt.rise_window_count = '0;
                    nxt.window_start_temp = tick.skin_temp;
                    nxt.phase             = PH_BOOST;
                    res.event_res         = EV_BOOST;
                end
                PH_BOOST:
                begin
                    nxt.rise_window_count = rise_cnt;
                    if (rise_cnt >= cfg.no_rise_timeout)
                    begin
                        if (no_rise)
                        begin
                            nxt.phase     = PH_SAFE;
                            res.event_res = EV_NO_RISE;
                            tripped       = 1'b1;
                        end
                        else
                        begin
                            nxt.window_start_temp = tick.skin_temp;
                            nxt.rise_window_count = '0;
                        end
                    end
                    if (!tripped && skin >= (target - ext_cfg(cfg.exit_margin)))
                    begin
                        nxt.coast_count = '0;
                        nxt.phase       = PH_COAST;
                        res.event_res   = EV_COAST;
                    end
                end
                PH_COAST:
                begin
                    nxt.coast_count = coast_cnt;
                    if (coast_cnt >= cfg.coast_length)
                    begin
                        res.seed_valid        = 1'b1;
                        res.seed_integral     = COAST_SEED;
                        res.seed_last_measure = tick.skin_temp;
                        nxt.low_count         = '0;
                        nxt.fast_drop_count   = '0;
                        nxt.phase             = PH_PID;
                        res.event_res         = EV_PID;
                    end
                end
                PH_PID:
                begin
                    if (fast && far)
                    begin
                        nxt.fast_drop_count = drop_cnt;
                        if (drop_cnt >= cfg.drop_count_limit)
                        begin
                            nxt.fast_drop_count = '0;
                            nxt.phase           = PH_SAFE;
                            res.event_res       = EV_DROP;
                            tripped             = 1'b1;
                        end
                    end
                    else
                    begin
                        nxt.fast_drop_count = '0;
                    end
                    if (!tripped)
                    begin
                        if (skin < (target - SUSTAIN_MARGIN))
                        begin
                            nxt.low_count = low_cnt;
                            if (low_cnt >= cfg.sustain_count_limit)
                            begin
                                nxt.low_count = '0;
                                nxt.phase     = PH_SAFE;
                                res.event_res = EV_LOW;
                            end
                        end
                        else
                        begin
                            nxt.low_count = '0;
                        end
                    end
                end
                PH_SAFE:
                begin
                    if (skin >= (target - RECOVER_MARGIN))
                    begin
                        res.seed_valid        = 1'b1;
                        res.seed_last_measure = tick.skin_temp;
                        nxt.phase             = PH_PID;
                        res.event_res         = EV_RECOVERED;
                    end
                end
                default:
                begin
                    nxt.phase     = PH_IDLE;
                    res.event_res = EV_IDLE;
                end
            endcase
        end
        res.phase = nxt.phase;
    end

endmodule
